// File: hdl/prc_pkg.sv
// Shared types and constants for the prime range counter.
// Used by the controller, the datapath and the top level; depends on nothing.
package prc_pkg;

   localparam int VALUE_BITS_DEF = 16;
   localparam int BOUND_W        = 16;
   localparam int COUNT_W        = 16;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic init_trial;
      logic start_div;
      logic div_step;
      logic next_divisor;
      logic next_number;
      logic bump_count;
      logic publish;
   } cmd_type;

   // Status from the datapath back to the controller
   typedef struct packed {
      logic n_below_hi;
      logic n_below_two;
      logic sq_above_n;
      logic div_last;
      logic rem_zero;
   } status_type;

endpackage

// File: hdl/prc_datapath.sv
// Datapath of the prime range counter: candidate, trial divisor and its square,
// bit-serial remainder unit, prime counter and result register.
// Depends on prc_pkg for the command and status structs.
module prc_datapath #(
   parameter int VALUE_BITS = prc_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic [prc_pkg::BOUND_W-1:0]   req_lower_bound,
   input  logic [prc_pkg::BOUND_W-1:0]   req_upper_bound,
   input  prc_pkg::cmd_type              cmd,
   output prc_pkg::status_type           sts,
   output logic [prc_pkg::COUNT_W-1:0]   rsp_prime_count
);

   localparam int W     = VALUE_BITS;
   localparam int SQ_W  = VALUE_BITS + 2;
   localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int EXT_W = VALUE_BITS + prc_pkg::BOUND_W;

   logic [W-1:0]                n_ff, n_in;
   logic [W-1:0]                hi_ff, hi_in;
   logic [W-1:0]                d_ff, d_in;
   logic [SQ_W-1:0]             sq_ff, sq_in;
   logic [W:0]                  rem_ff, rem_in;
   logic [W-1:0]                dvd_ff, dvd_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [prc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [prc_pkg::COUNT_W-1:0] result_ff, result_in;

   logic [EXT_W-1:0] lo_ext, hi_ext;
   logic [W:0]       rem_shift;
   logic [W:0]       d_wide;

   // Keep the low VALUE_BITS bits of each bound
   assign lo_ext    = {{W{1'b0}}, req_lower_bound};
   assign hi_ext    = {{W{1'b0}}, req_upper_bound};
   assign rem_shift = {rem_ff[W-1:0], dvd_ff[W-1]};
   assign d_wide    = {1'b0, d_ff};

   always_comb begin
      n_in      = n_ff;
      hi_in     = hi_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      cnt_in    = cnt_ff;
      count_in  = count_ff;
      result_in = result_ff;

      if (cmd.load_req) begin
         n_in     = lo_ext[W-1:0];
         hi_in    = hi_ext[W-1:0];
         count_in = '0;
      end
      if (cmd.init_trial) begin
         d_in  = W'(2);
         sq_in = SQ_W'(4);
      end
      if (cmd.start_div) begin
         rem_in = '0;
         dvd_in = n_ff;
         cnt_in = CNT_W'(W - 1);
      end
      if (cmd.div_step) begin
         // restoring step: shift in one dividend bit, subtract when it fits
         if (rem_shift >= d_wide) begin
            rem_in = rem_shift - d_wide;
         end else begin
            rem_in = rem_shift;
         end
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (cmd.next_divisor) begin
         // (d+1)^2 = d^2 + 2d + 1
         d_in  = d_ff + W'(1);
         sq_in = sq_ff + {1'b0, d_ff, 1'b1};
      end
      if (cmd.next_number) begin
         n_in = n_ff + W'(1);
      end
      if (cmd.bump_count) begin
         count_in = count_ff + prc_pkg::COUNT_W'(1);
      end
      if (cmd.publish) begin
         result_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      hi_ff     <= hi_in;
      d_ff      <= d_in;
      sq_ff     <= sq_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      cnt_ff    <= cnt_in;
      count_ff  <= count_in;
      result_ff <= result_in;
   end

   assign sts.n_below_hi  = (n_ff < hi_ff);
   assign sts.n_below_two = (n_ff[W-1:1] == '0);
   assign sts.sq_above_n  = (sq_ff > {2'b00, n_ff});
   assign sts.div_last    = (cnt_ff == '0);
   assign sts.rem_zero    = (rem_ff == '0);

   assign rsp_prime_count = result_ff;

endmodule

// File: hdl/prc_controller.sv
// Controller of the prime range counter: walks the range, runs the trial
// divisions and owns both handshakes. Depends on prc_pkg for the structs.
module prc_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  prc_pkg::status_type sts,
   output prc_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_TEST  = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_REM   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!sts.n_below_hi) begin
               state_in = ST_DONE;
            end else if (sts.n_below_two) begin
               cmd.next_number = 1'b1;
            end else begin
               cmd.init_trial = 1'b1;
               state_in       = ST_TEST;
            end
         end
         ST_TEST: begin
            if (sts.sq_above_n) begin
               cmd.bump_count  = 1'b1;
               cmd.next_number = 1'b1;
               state_in        = ST_CHECK;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_REM;
            end
         end
         ST_REM: begin
            if (sts.rem_zero) begin
               // divisor found: drop this candidate
               cmd.next_number = 1'b1;
               state_in        = ST_CHECK;
            end else begin
               cmd.next_divisor = 1'b1;
               state_in         = ST_TEST;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/prime_range_counter_core.sv
// Prime range counter: counts primes in [lower_bound, upper_bound) by trial division.
// Flow: per candidate, CHECK skips one that is below two; otherwise each trial divisor
//   tried runs TEST, the bit-serial division in DIV and REM, plus a final TEST when prime.
// Throughput: one transaction at a time; the bit-serial remainder unit sets the rate.
//   A new request is taken while the previous result still waits in the output register.
// Reset: synchronous, active high; clears the controller state and the result valid.
module prime_range_counter_core #(
   parameter int VALUE_BITS = prc_pkg::VALUE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [prc_pkg::BOUND_W-1:0] req_lower_bound,
   input  logic [prc_pkg::BOUND_W-1:0] req_upper_bound,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [prc_pkg::COUNT_W-1:0] rsp_prime_count
);

   prc_pkg::cmd_type    cmd;
   prc_pkg::status_type sts;

   prc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   prc_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .req_lower_bound (req_lower_bound),
      .req_upper_bound (req_upper_bound),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_prime_count (rsp_prime_count)
   );

`ifndef ASSERT_OFF
   // An accepted request keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while block still idle");

   // Never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !(rsp_valid && rsp_stall))
      else $error("pending result overwritten");

   // Load, division step, divisor update and publish are mutually exclusive
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_req, cmd.div_step, cmd.next_divisor, cmd.publish, cmd.start_div}))
      else $error("conflicting datapath commands");
`endif

endmodule
